// ----- src/feg_pkg.sv -----
package feg_pkg;

  // Default sizes; the top level hands these down as parameters.
  localparam int TIME_BITS_DEF  = 24;
  localparam int LEVEL_BITS_DEF = 16;

  // Fixed widths of the register file and the tick payload.
  localparam int SCALE_W    = 24;  // lengths, peak radius, radius level
  localparam int DT_W       = 16;  // delta_time
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FADE_IN_LEN  = 3'd0,
    REG_HOLD_LEN     = 3'd1,
    REG_FADE_OUT_LEN = 3'd2,
    REG_PEAK_ALPHA   = 3'd3,
    REG_PEAK_RADIUS  = 3'd4,
    REG_RADIUS_MODE  = 3'd5
  } feg_reg_e;

  // Phase code reported with every result beat.
  typedef enum logic [PHASE_W-1:0] {
    PHASE_IN   = 2'd0,
    PHASE_HOLD = 2'd1,
    PHASE_OUT  = 2'd2,
    PHASE_NONE = 2'd3
  } feg_phase_e;

  // Bit positions in the phase done flags.
  localparam int DONE_IN   = 0;
  localparam int DONE_HOLD = 1;
  localparam int DONE_OUT  = 2;

endpackage

// ----- src/feg_tick_if.sv -----
interface feg_tick_if;
  logic                     valid;
  logic                     ready;
  logic [feg_pkg::DT_W-1:0] delta_time;

  modport source (output valid, output delta_time, input ready);
  modport sink (input valid, input delta_time, output ready);
endinterface

// ----- src/feg_cfg_if.sv -----
interface feg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [feg_pkg::CFG_IDX_W-1:0]  index;
  logic [feg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/feg_level_if.sv -----
interface feg_level_if #(
  parameter int LEVEL_BITS = feg_pkg::LEVEL_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [LEVEL_BITS-1:0]       alpha_level;
  logic [feg_pkg::SCALE_W-1:0] radius_level;
  logic [feg_pkg::PHASE_W-1:0] phase;
  logic                        destroy_request;

  modport source (output valid, output alpha_level, output radius_level, output phase,
                  output destroy_request, input ready);
  modport sink (input valid, input alpha_level, input radius_level, input phase,
                input destroy_request, output ready);
endinterface

// ----- src/feg_scale.sv -----
// Computes peak * num / den: a multiply, then one restoring
// division step per cycle. Requires num <= den and den != 0.
module feg_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [feg_pkg::SCALE_W-1:0] peak_i,
  input  logic [feg_pkg::SCALE_W-1:0] num_i,
  input  logic [feg_pkg::SCALE_W-1:0] den_i,
  output logic                        done_o,
  output logic [feg_pkg::SCALE_W-1:0] quo_o
);
  localparam int W    = feg_pkg::SCALE_W;
  localparam int CntW = $clog2(W + 1);

  typedef enum logic [2:0] {
    SC_IDLE = 3'b001,
    SC_MUL  = 3'b010,
    SC_DIV  = 3'b100
  } feg_sc_state_e;

  feg_sc_state_e   state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;

  logic [W-1:0]   a_q, b_q, den_q;
  logic [W-1:0]   rem_q, low_q;
  logic [2*W-1:0] prod;
  logic [W:0]     trial, diff;
  logic           ge;

  assign prod  = a_q * b_q;
  assign trial = {rem_q, low_q[W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          state_d = SC_MUL;
        end
      end
      SC_MUL: begin
        cnt_d   = CntW'(W);
        state_d = SC_DIV;
      end
      SC_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = SC_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SC_IDLE && start_i) begin
      a_q   <= peak_i;
      b_q   <= num_i;
      den_q <= den_i;
    end
    if (state_q == SC_MUL) begin
      rem_q <= prod[2*W-1:W];
      low_q <= prod[W-1:0];
    end
    if (state_q == SC_DIV) begin
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
      low_q <= {low_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = low_q;

endmodule

// ----- src/fade_envelope_generator.sv -----
// Channel   | Dir | Payload                                          | Beat when
// ----------+-----+--------------------------------------------------+------------------
// tick_bus  | in  | delta_time                                       | valid & ready
// level_bus | out | alpha_level, radius_level, phase, destroy_request | valid & ready
// cfg_bus   | in  | index, data                                      | valid & ready
//
// One tick at a time. A tick with a ramp (fade-in or fade-out still running)
// passes through accept, update, operand load, multiply, the division steps
// of the shared scale unit, done and result. A tick without a ramp goes from
// its update straight to the result. cfg_bus is ready only in the idle state,
// so registers never change under a tick in flight. Reset (rst_ni low,
// asynchronous) clears counters, flags and registers and sets the alpha
// level to one half of full scale. A stalled result beat holds in the
// output register while the next tick can already be taken.
module fade_envelope_generator #(
  parameter int TIME_BITS  = feg_pkg::TIME_BITS_DEF,
  parameter int LEVEL_BITS = feg_pkg::LEVEL_BITS_DEF
) (
  input logic             clk_i,
  input logic             rst_ni,
  feg_cfg_if.sink         cfg_bus,
  feg_tick_if.sink        tick_bus,
  feg_level_if.source     level_bus
);
  localparam int SW    = feg_pkg::SCALE_W;
  localparam int DW    = feg_pkg::DT_W;
  localparam int CMP_W = (TIME_BITS > SW) ? TIME_BITS : SW;
  localparam int SUM_W = ((TIME_BITS > DW) ? TIME_BITS : DW) + 1;
  localparam logic [TIME_BITS-1:0] TimeMax  = '1;
  localparam logic [LEVEL_BITS-1:0] HalfLvl = LEVEL_BITS'(1) << (LEVEL_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CALC  = 5'b00010,
    S_NUM   = 5'b00100,
    S_SCALE = 5'b01000,
    S_DONE  = 5'b10000
  } feg_state_e;

  feg_state_e state_q;

  // Register file
  logic [SW-1:0]         fade_in_len_q, hold_len_q, fade_out_len_q, peak_radius_q;
  logic [LEVEL_BITS-1:0] peak_alpha_q;
  logic                  radius_mode_q;

  // Envelope state
  logic [TIME_BITS-1:0]  in_elapsed_q, hold_elapsed_q, out_elapsed_q;
  logic [2:0]            done_q;
  logic [LEVEL_BITS-1:0] alpha_now_q;
  logic [SW-1:0]         radius_now_q;

  // Per-tick working registers
  logic [DW-1:0]         dt_q;
  feg_pkg::feg_phase_e   phase_q;
  logic                  destroy_q;
  logic                  is_out_q;
  logic [SW-1:0]         elap_q, den_q;

  // Output register
  logic                  out_valid_q;
  logic [LEVEL_BITS-1:0] out_alpha_q;
  logic [SW-1:0]         out_radius_q;
  logic [1:0]            out_phase_q;
  logic                  out_destroy_q;

  logic                  tick_beat, cfg_beat, out_free;
  logic                  run_in, run_hold, run_out;
  feg_pkg::feg_phase_e   calc_phase;
  logic [TIME_BITS-1:0]  cur_elapsed, sum_sat;
  logic [SW-1:0]         cur_len;
  logic [SUM_W-1:0]      sum_raw;
  logic                  complete;

  logic                  scale_done;
  logic [SW-1:0]         scale_peak, scale_num, scale_quo;

  assign tick_beat      = tick_bus.valid && tick_bus.ready;
  assign cfg_beat       = cfg_bus.valid && cfg_bus.ready;
  assign tick_bus.ready = (state_q == S_IDLE);
  assign cfg_bus.ready  = (state_q == S_IDLE);
  assign out_free       = !out_valid_q || level_bus.ready;

  // Pick the first phase that has a length and is not done.
  assign run_in   = (fade_in_len_q != '0) && !done_q[feg_pkg::DONE_IN];
  assign run_hold = (hold_len_q != '0) && !done_q[feg_pkg::DONE_HOLD];
  assign run_out  = (fade_out_len_q != '0) && !done_q[feg_pkg::DONE_OUT];

  always_comb begin
    if (run_in) begin
      calc_phase  = feg_pkg::PHASE_IN;
      cur_elapsed = in_elapsed_q;
      cur_len     = fade_in_len_q;
    end else if (run_hold) begin
      calc_phase  = feg_pkg::PHASE_HOLD;
      cur_elapsed = hold_elapsed_q;
      cur_len     = hold_len_q;
    end else if (run_out) begin
      calc_phase  = feg_pkg::PHASE_OUT;
      cur_elapsed = out_elapsed_q;
      cur_len     = fade_out_len_q;
    end else begin
      calc_phase  = feg_pkg::PHASE_NONE;
      cur_elapsed = '0;
      cur_len     = '0;
    end
  end

  // Advance the running counter, saturating at its top value.
  assign sum_raw = SUM_W'(cur_elapsed) + SUM_W'(dt_q);
  assign sum_sat = (sum_raw > SUM_W'(TimeMax)) ? TimeMax : sum_raw[TIME_BITS-1:0];

  // Fade-out ends only once the count passes its length; the others on reaching it.
  assign complete = (calc_phase == feg_pkg::PHASE_OUT) ?
                    (CMP_W'(sum_sat) >  CMP_W'(cur_len)) :
                    (CMP_W'(sum_sat) >= CMP_W'(cur_len));

  // Ramp operands: the count never exceeds the length when a ramp is taken.
  assign scale_peak = radius_mode_q ? peak_radius_q : SW'(peak_alpha_q);
  assign scale_num  = is_out_q ? (den_q - elap_q) : elap_q;

  feg_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == S_NUM),
    .peak_i (scale_peak),
    .num_i  (scale_num),
    .den_i  (den_q),
    .done_o (scale_done),
    .quo_o  (scale_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      fade_in_len_q  <= '0;
      hold_len_q     <= '0;
      fade_out_len_q <= '0;
      peak_alpha_q   <= '0;
      peak_radius_q  <= '0;
      radius_mode_q  <= 1'b0;
      in_elapsed_q   <= '0;
      hold_elapsed_q <= '0;
      out_elapsed_q  <= '0;
      done_q         <= '0;
      alpha_now_q    <= HalfLvl;
      radius_now_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      // Register writes; a length write reopens its phase.
      if (cfg_beat) begin
        case (feg_pkg::feg_reg_e'(cfg_bus.index))
          feg_pkg::REG_FADE_IN_LEN: begin
            fade_in_len_q <= cfg_bus.data[SW-1:0];
            done_q[feg_pkg::DONE_IN] <= 1'b0;
          end
          feg_pkg::REG_HOLD_LEN: begin
            hold_len_q <= cfg_bus.data[SW-1:0];
            done_q[feg_pkg::DONE_HOLD] <= 1'b0;
          end
          feg_pkg::REG_FADE_OUT_LEN: begin
            fade_out_len_q <= cfg_bus.data[SW-1:0];
            done_q[feg_pkg::DONE_OUT] <= 1'b0;
          end
          feg_pkg::REG_PEAK_ALPHA: begin
            peak_alpha_q <= cfg_bus.data[LEVEL_BITS-1:0];
            alpha_now_q  <= cfg_bus.data[LEVEL_BITS-1:0];
          end
          feg_pkg::REG_PEAK_RADIUS: peak_radius_q <= cfg_bus.data[SW-1:0];
          feg_pkg::REG_RADIUS_MODE: radius_mode_q <= cfg_bus.data[0];
          default: ;
        endcase
      end

      // Load a new result beat, or drop the one just taken.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (level_bus.valid && level_bus.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (tick_beat) begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          state_q <= S_DONE;
          case (calc_phase)
            feg_pkg::PHASE_IN: begin
              if (complete) begin
                in_elapsed_q <= '0;
                done_q[feg_pkg::DONE_IN] <= 1'b1;
              end else begin
                in_elapsed_q <= sum_sat;
                state_q      <= S_NUM;
              end
            end
            feg_pkg::PHASE_HOLD: begin
              if (complete) begin
                hold_elapsed_q <= '0;
                done_q[feg_pkg::DONE_HOLD] <= 1'b1;
              end else begin
                hold_elapsed_q <= sum_sat;
              end
              // Hold drives the peak, also on its last tick.
              if (radius_mode_q) begin
                radius_now_q <= peak_radius_q;
              end else begin
                alpha_now_q <= peak_alpha_q;
              end
            end
            feg_pkg::PHASE_OUT: begin
              if (complete) begin
                out_elapsed_q <= '0;
                done_q[feg_pkg::DONE_OUT] <= 1'b1;
                if (radius_mode_q) begin
                  radius_now_q <= '0;
                end else begin
                  alpha_now_q <= '0;
                end
              end else begin
                out_elapsed_q <= sum_sat;
                state_q       <= S_NUM;
              end
            end
            default: ;
          endcase
        end
        S_NUM: state_q <= S_SCALE;
        S_SCALE: begin
          if (scale_done) begin
            if (radius_mode_q) begin
              radius_now_q <= scale_quo;
            end else begin
              alpha_now_q <= scale_quo[LEVEL_BITS-1:0];
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working and result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (tick_beat) begin
      dt_q <= tick_bus.delta_time;
    end
    if (state_q == S_CALC) begin
      phase_q   <= calc_phase;
      destroy_q <= (calc_phase == feg_pkg::PHASE_OUT) && complete;
      is_out_q  <= (calc_phase == feg_pkg::PHASE_OUT);
      elap_q    <= SW'(sum_sat);
      den_q     <= cur_len;
    end
    if (state_q == S_DONE && out_free) begin
      out_alpha_q   <= alpha_now_q;
      out_radius_q  <= radius_now_q;
      out_phase_q   <= phase_q;
      out_destroy_q <= destroy_q;
    end
  end

  assign level_bus.valid           = out_valid_q;
  assign level_bus.alpha_level     = out_alpha_q;
  assign level_bus.radius_level    = out_radius_q;
  assign level_bus.phase           = out_phase_q;
  assign level_bus.destroy_request = out_destroy_q;

endmodule

// ----- src/feg_checker.sv -----
module feg_checker #(
  parameter int LEVEL_BITS = feg_pkg::LEVEL_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        tick_valid_i,
  input logic                        tick_ready_i,
  input logic                        lvl_valid_i,
  input logic                        lvl_ready_i,
  input logic [LEVEL_BITS-1:0]       alpha_level_i,
  input logic [feg_pkg::SCALE_W-1:0] radius_level_i,
  input logic [feg_pkg::PHASE_W-1:0] phase_i,
  input logic                        destroy_request_i
);

  // Stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_valid_i && !lvl_ready_i |=> lvl_valid_i && $stable(alpha_level_i) &&
      $stable(radius_level_i) && $stable(phase_i) && $stable(destroy_request_i))
    else $error("result beat changed while stalled");

  // Destroy only comes out of fade-out.
  a_destroy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_valid_i && destroy_request_i |-> phase_i == feg_pkg::PHASE_OUT)
    else $error("destroy request outside fade-out");

  // The ramped level drops to zero when fade-out ends.
  a_destroy_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_valid_i && destroy_request_i |-> alpha_level_i == '0 || radius_level_i == '0)
    else $error("destroy request with nonzero levels");

  // One tick in flight: no tick taken right after a tick beat.
  a_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_valid_i && tick_ready_i |=> !tick_ready_i)
    else $error("tick taken while the previous one is in flight");

endmodule

bind fade_envelope_generator feg_checker #(.LEVEL_BITS(LEVEL_BITS)) u_feg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .tick_valid_i     (tick_bus.valid),
  .tick_ready_i     (tick_bus.ready),
  .lvl_valid_i      (level_bus.valid),
  .lvl_ready_i      (level_bus.ready),
  .alpha_level_i    (level_bus.alpha_level),
  .radius_level_i   (level_bus.radius_level),
  .phase_i          (level_bus.phase),
  .destroy_request_i(level_bus.destroy_request)
);

// ----- tb/feg_level_checker.sv -----
`timescale 1ns / 100ps

module feg_level_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  feg_cfg_if    cfg_mon,
  feg_tick_if   tick_mon,
  feg_level_if  level_mon,
  output int    mismatches_o,
  output int    pending_o,
  output int    beats_o,
  output int    destroys_o
);
  import feg_pkg::*;

  localparam int TIME_W       = TIME_BITS_DEF;
  localparam int LEVEL_W      = LEVEL_BITS_DEF;

  typedef struct packed {
    logic [LEVEL_W-1:0] alpha;
    logic [SCALE_W-1:0] radius;
    feg_phase_e         phase;
    logic               destroy;
  } level_beat_t;

  // Envelope registers and state, as the block should hold them.
  logic [SCALE_W-1:0] fade_in_len, hold_len, fade_out_len;
  logic [LEVEL_W-1:0] peak_alpha;
  logic [SCALE_W-1:0] peak_radius;
  logic               radius_mode;
  logic [TIME_W-1:0]  fade_in_el, hold_el, fade_out_el;
  logic [2:0]         done_flags;
  logic [LEVEL_W-1:0] alpha_now;
  logic [SCALE_W-1:0] radius_now;

  level_beat_t level_exp_q[$];
  int n_mismatch;
  int n_beats;
  int n_destroys;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_mismatch++;
    $display("%0t: level beat %0d, %s: got 0x%0h, want 0x%0h",
             $time, n_beats, what, got, want);
  endtask

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] acc,
                                                input logic [DT_W-1:0] dt);
    logic [TIME_W:0] sum;
    sum = acc + dt;
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

  // Set the selected level to peak * num / den, truncated.
  function automatic void ramp_level(input logic [SCALE_W-1:0] num,
                                     input logic [SCALE_W-1:0] den);
    logic [63:0] prod, n, d;
    if (radius_mode) prod = 64'(peak_radius);
    else prod = 64'(peak_alpha);
    n = 64'(num);
    d = 64'(den);
    prod = (prod * n) / d;
    if (radius_mode) radius_now = prod[SCALE_W-1:0];
    else alpha_now = prod[LEVEL_W-1:0];
  endfunction

  // Advance the envelope by one tick and return the level beat it produces.
  function automatic level_beat_t step_envelope(input logic [DT_W-1:0] dt);
    level_beat_t res;
    res.phase   = PHASE_NONE;
    res.destroy = 1'b0;
    if (fade_in_len != '0 && !done_flags[DONE_IN]) begin
      res.phase  = PHASE_IN;
      fade_in_el = sat_add(fade_in_el, dt);
      if (fade_in_el >= fade_in_len) begin
        fade_in_el          = '0;
        done_flags[DONE_IN] = 1'b1;
      end else begin
        ramp_level(fade_in_el, fade_in_len);
      end
    end else if (hold_len != '0 && !done_flags[DONE_HOLD]) begin
      res.phase = PHASE_HOLD;
      hold_el   = sat_add(hold_el, dt);
      if (hold_el >= hold_len) begin
        hold_el               = '0;
        done_flags[DONE_HOLD] = 1'b1;
      end
      if (radius_mode) radius_now = peak_radius;
      else alpha_now = peak_alpha;
    end else if (fade_out_len != '0 && !done_flags[DONE_OUT]) begin
      res.phase   = PHASE_OUT;
      fade_out_el = sat_add(fade_out_el, dt);
      if (fade_out_el > fade_out_len) begin
        fade_out_el          = '0;
        done_flags[DONE_OUT] = 1'b1;
        res.destroy          = 1'b1;
        if (radius_mode) radius_now = '0;
        else alpha_now = '0;
      end else begin
        ramp_level(fade_out_len - fade_out_el, fade_out_len);
      end
    end
    res.alpha  = alpha_now;
    res.radius = radius_now;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    level_beat_t want;
    if (!rst_ni) begin
      fade_in_len  = '0;
      hold_len     = '0;
      fade_out_len = '0;
      peak_alpha   = '0;
      peak_radius  = '0;
      radius_mode  = 1'b0;
      fade_in_el   = '0;
      hold_el      = '0;
      fade_out_el  = '0;
      done_flags   = '0;
      alpha_now    = {1'b1, {(LEVEL_W-1){1'b0}}};
      radius_now   = '0;
      level_exp_q.delete();
      n_mismatch   = 0;
      n_beats      = 0;
      n_destroys   = 0;
    end else begin
      // Retire the oldest expectation before this edge's tick adds a new one.
      if (level_mon.valid && level_mon.ready) begin
        n_beats++;
        if (level_exp_q.size() == 0) begin
          report_mismatch("beat with nothing expected", level_mon.alpha_level, '0);
        end else begin
          want = level_exp_q.pop_front();
          if (level_mon.alpha_level !== want.alpha)
            report_mismatch("alpha_level", level_mon.alpha_level, want.alpha);
          if (level_mon.radius_level !== want.radius)
            report_mismatch("radius_level", level_mon.radius_level, want.radius);
          if (level_mon.phase !== want.phase)
            report_mismatch("phase", level_mon.phase, want.phase);
          if (level_mon.destroy_request !== want.destroy)
            report_mismatch("destroy_request", level_mon.destroy_request, want.destroy);
          if (want.destroy) n_destroys++;
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_FADE_IN_LEN: begin
            fade_in_len         = cfg_mon.data;
            done_flags[DONE_IN] = 1'b0;
          end
          REG_HOLD_LEN: begin
            hold_len              = cfg_mon.data;
            done_flags[DONE_HOLD] = 1'b0;
          end
          REG_FADE_OUT_LEN: begin
            fade_out_len         = cfg_mon.data;
            done_flags[DONE_OUT] = 1'b0;
          end
          REG_PEAK_ALPHA: begin
            peak_alpha = cfg_mon.data[LEVEL_W-1:0];
            alpha_now  = cfg_mon.data[LEVEL_W-1:0];
          end
          REG_PEAK_RADIUS: peak_radius = cfg_mon.data;
          REG_RADIUS_MODE: radius_mode = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (tick_mon.valid && tick_mon.ready) begin
        level_exp_q.push_back(step_envelope(tick_mon.delta_time));
      end
    end
    mismatches_o <= n_mismatch;
    pending_o    <= level_exp_q.size();
    beats_o      <= n_beats;
    destroys_o   <= n_destroys;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import feg_pkg::*;

  localparam int TICK_TARGET     = 550;  // stop random stimulus near this many ticks
  localparam int SAT_TICKS       = 262;  // enough max-size ticks to pin a counter
  localparam int IDLE_PCT        = 16;   // chance per cycle that a side idles
  localparam int RX_STALL_CYCLES = 400;  // long receiver hold-off
  localparam int WATCHDOG_LIMIT  = 4000; // cycles without any beat
  localparam int TAIL_CYCLES     = 40;   // longer than one ramp tick takes
  localparam int REG_SLOTS       = 1 << CFG_IDX_W;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [CFG_DATA_W-1:0] MODE_ALPHA  = '0;
  localparam logic [CFG_DATA_W-1:0] MODE_RADIUS = 1;

  logic clk_i;
  logic rst_ni;

  feg_cfg_if                                  cfg_bus();
  feg_tick_if                                 tick_bus();
  feg_level_if #(.LEVEL_BITS(LEVEL_BITS_DEF)) level_bus();

  logic calm;          // both sides run without idling while set
  int   stall_asked;   // hold-offs requested by the stimulus
  int   stall_given;   // hold-offs carried out by the receiver
  int   quiet_cycles;
  int   ticks_sent;
  int   reg_writes;
  int   setups;

  int   mismatches;
  int   pending;
  int   beats;
  int   destroys;

  fade_envelope_generator u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_bus   (cfg_bus),
    .tick_bus  (tick_bus),
    .level_bus (level_bus)
  );

  feg_level_checker u_level_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_bus),
    .tick_mon     (tick_bus),
    .level_mon    (level_bus),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .beats_o      (beats),
    .destroys_o   (destroys)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver: accept level beats, idling at random unless calm. Hold ready
  // low for a long stretch whenever the stimulus asks, counting the cycles
  // here so the sender keeps offering ticks and the block backs up.
  initial begin
    level_bus.ready = 1'b0;
    stall_given     = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_given < stall_asked) begin
        stall_given++;
        level_bus.ready <= 1'b0;
        repeat (RX_STALL_CYCLES) @(posedge clk_i);
      end
      level_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (tick_bus.valid && tick_bus.ready) ||
        (level_bus.valid && level_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d level beats still owed",
               $time, quiet_cycles, pending);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one tick, idling at random first; leave valid high after the beat.
  task automatic send_tick(input logic [DT_W-1:0] dt);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      tick_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_bus.valid      <= 1'b1;
    tick_bus.delta_time <= dt;
    do @(posedge clk_i); while (!tick_bus.ready);
    ticks_sent++;
  endtask

  // Drop tick valid and wait until every owed level beat has arrived.
  task automatic drain_levels();
    tick_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Write every register index, the two spare ones included, while idle.
  task automatic program_envelope(input logic [SCALE_W-1:0] fade_in, hold, fade_out,
                                  input logic [CFG_DATA_W-1:0] alpha, radius, mode);
    logic [CFG_DATA_W-1:0] cfg_image [REG_SLOTS];
    drain_levels();
    cfg_image[REG_FADE_IN_LEN]  = fade_in;
    cfg_image[REG_HOLD_LEN]     = hold;
    cfg_image[REG_FADE_OUT_LEN] = fade_out;
    cfg_image[REG_PEAK_ALPHA]   = alpha;
    cfg_image[REG_PEAK_RADIUS]  = radius;
    cfg_image[REG_RADIUS_MODE]  = mode;
    cfg_image[REG_SPARE_LO]     = CFG_DATA_W'($urandom());
    cfg_image[REG_SPARE_HI]     = CFG_DATA_W'($urandom());
    for (int i = 0; i < REG_SLOTS; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= i[CFG_IDX_W-1:0];
      cfg_bus.data  <= cfg_image[i];
      do @(posedge clk_i); while (!cfg_bus.ready);
      reg_writes++;
    end
    cfg_bus.valid <= 1'b0;
    setups++;
  endtask

  // Mostly short lengths so envelopes finish; sometimes skip, sometimes huge.
  function automatic logic [SCALE_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SCALE_W'($urandom());
      default: return SCALE_W'($urandom_range(1, 300));
    endcase
  endfunction

  initial begin
    int               scene;
    int               burst;
    int               roll;
    logic [DT_W-1:0]  dt;

    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = '0;
    cfg_bus.data        = '0;
    tick_bus.valid      = 1'b0;
    tick_bus.delta_time = '0;
    calm                = 1'b0;
    stall_asked         = 0;
    quiet_cycles        = 0;
    ticks_sent          = 0;
    reg_writes          = 0;
    setups              = 0;
    scene               = 0;
    rst_ni              = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset every length is zero: no phase runs, alpha sits at half.
    send_tick('0);
    send_tick('1);

    // Full alpha envelope: fade-in completes on an exact hit and keeps its
    // level, hold completes, fade-out reaches zero at its length and then
    // completes one unit later with a destroy request, then nothing runs.
    program_envelope(100, 50, 100, 16'hFFFF, '0, MODE_ALPHA);
    send_tick(0);
    send_tick(40);
    send_tick(60);
    send_tick(25);
    send_tick(25);
    send_tick(50);
    send_tick(50);
    send_tick(1);
    send_tick(7);

    // Radius mode at full peak with unit lengths and extreme deltas; alpha
    // holds the value just loaded by its peak write.
    program_envelope(1, 1, 1, '0, 24'hFF_FFFF, MODE_RADIUS);
    send_tick('1);
    send_tick(0);
    send_tick('1);
    send_tick(0);
    send_tick(1);
    send_tick(1);

    // Rewrite a length mid-phase: the elapsed count carries over. Upper data
    // bits beyond each register's width must be ignored.
    program_envelope(10, 0, 0, 24'hAB_CD12, 24'h5A_5A5A, 24'hFF_FFFE);
    send_tick(3);
    send_tick(3);
    program_envelope(20, 0, 0, 24'hAB_CD12, 24'h5A_5A5A, 24'hFF_FFFE);
    send_tick(4);
    send_tick(20);

    // Longest fade-out with max deltas: its counter pins at full scale and
    // can never pass the length, so no destroy request may appear.
    program_envelope(0, 0, '1, CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                     CFG_DATA_W'($urandom()));
    repeat (SAT_TICKS) send_tick('1);

    // Random envelopes, sometimes continued without a rewrite.
    while (ticks_sent < TICK_TARGET) begin
      scene++;
      calm <= (scene >= 6 && scene < 11);
      if (scene == 1 || $urandom_range(0, 3) != 0) begin
        program_envelope(pick_len(), pick_len(), pick_len(), CFG_DATA_W'($urandom()),
                         CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
      end
      // Start the hold-off only once the setup is done, so ticks pile up behind it.
      if (scene == 3) stall_asked <= stall_asked + 1;
      burst = (scene == 3) ? 40 : $urandom_range(6, 36);
      repeat (burst) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) dt = '0;
        else if (roll < 3) dt = DT_W'($urandom());
        else dt = DT_W'($urandom_range(1, 50));
        send_tick(dt);
      end
    end

    drain_levels();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Drove %0d ticks over %0d register setups (%0d writes), with a saturating",
             ticks_sent, setups, reg_writes);
    $display("fade-out and a %0d-cycle receiver hold-off; %0d level beats checked, %0d destroys.",
             RX_STALL_CYCLES, beats, destroys);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
